### hdl/agbb_pkg.sv
// Package for the alpha glyph blit blend block: shared constants, the
// configuration register set and the register index codes. No dependencies.
`default_nettype none

package agbb_pkg;

   localparam int DEF_MAX_DIM  = 4096;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int COORD_W      = 13;
   localparam int GRAY_W       = 8;
   localparam int PIX_POS_W    = 14;
   localparam int PIX_WORD_W   = 32;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 64;
   localparam logic [GRAY_W-1:0] OPAQUE_ALPHA = 8'hFF;
   localparam logic [GRAY_W-1:0] FULL_ALPHA   = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ORIGIN_X    = 8'd0,
      REG_ORIGIN_Y    = 8'd1,
      REG_GLYPH_WIDTH = 8'd2,
      REG_CLIP_LEFT   = 8'd3,
      REG_CLIP_TOP    = 8'd4,
      REG_CLIP_RIGHT  = 8'd5,
      REG_CLIP_BOTTOM = 8'd6,
      REG_INK_GRAY    = 8'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0]        glyph_width;
      logic [COORD_W-1:0]        clip_left;
      logic [COORD_W-1:0]        clip_top;
      logic [COORD_W-1:0]        clip_right;
      logic [COORD_W-1:0]        clip_bottom;
      logic [GRAY_W-1:0]         ink_gray;
   } cfg_type;

   // Counter width for a given glyph dimension limit.
   function automatic int count_width(input int max_dim);
      return $clog2(max_dim);
   endfunction

   // Width that holds a wrapped column count plus one, and a 13-bit register.
   function automatic int cmp_width(input int max_dim);
      return (($clog2(max_dim) + 1) > COORD_W) ? ($clog2(max_dim) + 1) : COORD_W;
   endfunction

   // Signed width of a full canvas position (origin plus counter).
   function automatic int pos_width(input int max_dim);
      return cmp_width(max_dim) + 1;
   endfunction

endpackage : agbb_pkg

`default_nettype wire

### hdl/alpha_glyph_blit_blend.sv
// Top level of the alpha glyph blit blend block: streaming ports, two-stage
// pipeline. Depends on agbb_pkg, agbb_csr, agbb_pos and agbb_blend.
`default_nettype none

// The block takes one glyph coverage byte per transaction, in row-major order,
// together with the current gray of the destination pixel, and returns one
// result per transaction: the target canvas position (origin plus the internal
// column and row counters), a write enable that is set when that position lies
// in the clip window and alpha is nonzero, and the blended opaque gray ARGB
// word (zero when nothing is written). A transaction with req_tlast set ends
// the glyph and returns both counters to zero. It accepts one transaction per
// clock cycle while rsp_tready does not hold back the output: the first
// register stage holds the item with its position, the second holds the result,
// and the input keeps flowing while a result waits on rsp_tready as long as the
// first stage has room. The counter width follows MAX_DIM. Registers are
// written through the csr_ port, whose writes complete in the cycle they are
// offered; they should be changed only while no transaction is in flight.
module alpha_glyph_blit_blend #(
   parameter int MAX_DIM = agbb_pkg::DEF_MAX_DIM
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input stream.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [7:0] alpha, [15:8] dest_gray.
   input  wire logic [agbb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                             req_tlast,
   // Result stream.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [13:0] pixel_x, [27:14] pixel_y, [59:28] pixel_word, [63:60] zero.
   output logic [agbb_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [0] write_enable.
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   // Configuration write port.
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [agbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [agbb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import agbb_pkg::*;

   localparam int PW = pos_width(MAX_DIM);

   cfg_type cfg;

   // First stage: the accepted item and its canvas position.
   logic                  s0_valid_ff, s0_valid_in;
   logic [GRAY_W-1:0]     s0_alpha_ff, s0_dest_ff;
   logic                  s0_last_ff;
   logic signed [PW-1:0]  s0_x_ff, s0_y_ff;
   logic                  s0_ready;

   // Second stage: the result held for the output.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_we_ff;
   logic [PIX_POS_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [PIX_WORD_W-1:0] rsp_word_ff;
   logic                  rsp_last_ff;
   logic                  s1_ready;

   logic                  req_fire;
   logic signed [PW-1:0]  pos_x, pos_y;
   logic                  blend_we;
   logic [PIX_WORD_W-1:0] blend_word;

   agbb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   agbb_pos #(
      .MAX_DIM (MAX_DIM)
   ) u_pos (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (req_fire),
      .glyph_end (req_tlast),
      .pos_x     (pos_x),
      .pos_y     (pos_y)
   );

   agbb_blend #(
      .MAX_DIM (MAX_DIM)
   ) u_blend (
      .cfg          (cfg),
      .alpha        (s0_alpha_ff),
      .dest_gray    (s0_dest_ff),
      .pos_x        (s0_x_ff),
      .pos_y        (s0_y_ff),
      .write_enable (blend_we),
      .pixel_word   (blend_word)
   );

   // A stage takes new data when it is empty or its contents move on.
   assign s1_ready   = !rsp_valid_ff || rsp_tready;
   assign s0_ready   = !s0_valid_ff || s1_ready;
   assign req_tready = s0_ready;
   assign req_fire   = req_tvalid && s0_ready;

   assign s0_valid_in  = s0_ready ? req_tvalid : s0_valid_ff;
   assign rsp_valid_in = s1_ready ? s0_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_alpha_ff <= req_tdata[GRAY_W-1:0];
         s0_dest_ff  <= req_tdata[2*GRAY_W-1:GRAY_W];
         s0_last_ff  <= req_tlast;
         s0_x_ff     <= pos_x;
         s0_y_ff     <= pos_y;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s0_valid_ff) begin
         rsp_we_ff   <= blend_we;
         rsp_x_ff    <= s0_x_ff[PIX_POS_W-1:0];
         rsp_y_ff    <= s0_y_ff[PIX_POS_W-1:0];
         rsp_word_ff <= blend_word;
         rsp_last_ff <= s0_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*PIX_POS_W-PIX_WORD_W){1'b0}},
                        rsp_word_ff, rsp_y_ff, rsp_x_ff};

endmodule : alpha_glyph_blit_blend

`default_nettype wire

### hdl/agbb_csr.sv
// Configuration register file of the glyph blit blend block.
// Depends on agbb_pkg for the register set and index codes.
`default_nettype none

module agbb_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [agbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [agbb_pkg::CSR_DATA_W-1:0]  csr_data,
   output agbb_pkg::cfg_type                     cfg
);
   import agbb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ORIGIN_X:    cfg_in.origin_x    = signed'(csr_data[COORD_W-1:0]);
            REG_ORIGIN_Y:    cfg_in.origin_y    = signed'(csr_data[COORD_W-1:0]);
            REG_GLYPH_WIDTH: cfg_in.glyph_width = csr_data[COORD_W-1:0];
            REG_CLIP_LEFT:   cfg_in.clip_left   = csr_data[COORD_W-1:0];
            REG_CLIP_TOP:    cfg_in.clip_top    = csr_data[COORD_W-1:0];
            REG_CLIP_RIGHT:  cfg_in.clip_right  = csr_data[COORD_W-1:0];
            REG_CLIP_BOTTOM: cfg_in.clip_bottom = csr_data[COORD_W-1:0];
            REG_INK_GRAY:    cfg_in.ink_gray    = csr_data[GRAY_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.glyph_width <= COORD_W'(1);
         cfg_ff.clip_left   <= '0;
         cfg_ff.clip_top    <= '0;
         cfg_ff.clip_right  <= COORD_W'(4096);
         cfg_ff.clip_bottom <= COORD_W'(4096);
         cfg_ff.ink_gray    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule : agbb_csr

`default_nettype wire

### hdl/agbb_pos.sv
// Column and row counters of the glyph walk and the target canvas position.
// Depends on agbb_pkg for widths and the configuration struct.
`default_nettype none

module agbb_pos #(
   parameter int MAX_DIM = agbb_pkg::DEF_MAX_DIM
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire agbb_pkg::cfg_type                            cfg,
   input  wire logic                                         advance,
   input  wire logic                                         glyph_end,
   output logic signed [agbb_pkg::pos_width(MAX_DIM)-1:0]    pos_x,
   output logic signed [agbb_pkg::pos_width(MAX_DIM)-1:0]    pos_y
);
   import agbb_pkg::*;

   localparam int CW = count_width(MAX_DIM);
   localparam int GW = cmp_width(MAX_DIM);
   localparam int PW = pos_width(MAX_DIM);
   localparam logic [GW-1:0] MAX_DIM_G = GW'(MAX_DIM);

   logic [CW-1:0] column_ff, column_in;
   logic [CW-1:0] row_ff, row_in;
   logic [GW-1:0] next_col;
   logic [GW-1:0] next_row;

   assign pos_x = $signed({{(PW-COORD_W){cfg.origin_x[COORD_W-1]}}, cfg.origin_x})
                + $signed({{(PW-CW){1'b0}}, column_ff});
   assign pos_y = $signed({{(PW-COORD_W){cfg.origin_y[COORD_W-1]}}, cfg.origin_y})
                + $signed({{(PW-CW){1'b0}}, row_ff});

   assign next_col = GW'(column_ff) + GW'(1);
   assign next_row = GW'(row_ff) + GW'(1);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (glyph_end) begin
            column_in = '0;
            row_in    = '0;
         end else if (next_col >= GW'(cfg.glyph_width) || next_col >= MAX_DIM_G) begin
            // End of a glyph row: wrap the column, step the row.
            column_in = '0;
            row_in    = (next_row >= MAX_DIM_G) ? '0 : next_row[CW-1:0];
         end else begin
            column_in = next_col[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule : agbb_pos

`default_nettype wire

### hdl/agbb_blend.sv
// Clip test and alpha blend of one pixel, purely combinational.
// Depends on agbb_pkg for widths, constants and the configuration struct.
`default_nettype none

module agbb_blend #(
   parameter int MAX_DIM = agbb_pkg::DEF_MAX_DIM
) (
   input  wire agbb_pkg::cfg_type                            cfg,
   input  wire logic [agbb_pkg::GRAY_W-1:0]                  alpha,
   input  wire logic [agbb_pkg::GRAY_W-1:0]                  dest_gray,
   input  wire logic signed [agbb_pkg::pos_width(MAX_DIM)-1:0] pos_x,
   input  wire logic signed [agbb_pkg::pos_width(MAX_DIM)-1:0] pos_y,
   output logic                                              write_enable,
   output logic [agbb_pkg::PIX_WORD_W-1:0]                   pixel_word
);
   import agbb_pkg::*;

   localparam int PW = pos_width(MAX_DIM);
   localparam int SW = 2 * GRAY_W;

   logic signed [PW-1:0] left_s, right_s, top_s, bottom_s;
   logic                 in_clip;
   logic [SW-1:0]        ink_part, dest_part, blend_sum;
   logic [SW:0]          quot_pre;
   logic [GRAY_W-1:0]    gray;

   assign left_s   = $signed({{(PW-COORD_W){1'b0}}, cfg.clip_left});
   assign right_s  = $signed({{(PW-COORD_W){1'b0}}, cfg.clip_right});
   assign top_s    = $signed({{(PW-COORD_W){1'b0}}, cfg.clip_top});
   assign bottom_s = $signed({{(PW-COORD_W){1'b0}}, cfg.clip_bottom});

   assign in_clip = (pos_x >= left_s) && (pos_x < right_s) &&
                    (pos_y >= top_s)  && (pos_y < bottom_s);
   assign write_enable = in_clip && (alpha != '0);

   assign ink_part  = cfg.ink_gray * alpha;
   assign dest_part = dest_gray * (FULL_ALPHA - alpha);
   assign blend_sum = ink_part + dest_part;

   // Floor division by 255 for sums up to 255*255: (s + (s >> 8) + 1) >> 8.
   assign quot_pre = {1'b0, blend_sum} + (SW+1)'(blend_sum[SW-1:GRAY_W]) + (SW+1)'(1);
   assign gray     = quot_pre[SW-1:GRAY_W];

   assign pixel_word = write_enable ? {OPAQUE_ALPHA, gray, gray, gray} : '0;

endmodule : agbb_blend

`default_nettype wire

### hdl/agbb_checker.sv
// Port-level checker for alpha_glyph_blit_blend and the bind that attaches it.
// Depends only on the top level's ports.
`default_nettype none

module agbb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A written pixel is opaque gray: alpha byte 0xFF and three equal channels.
   a_opaque_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[59:52] == 8'hFF &&
      rsp_tdata[51:44] == rsp_tdata[43:36] && rsp_tdata[43:36] == rsp_tdata[35:28])
      else $error("written pixel word is not opaque gray");

   // A result without a write carries a zero pixel word.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[59:28] == 32'h0)
      else $error("pixel word nonzero without write");

   // With the output stage empty the input side must have room.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule : agbb_checker

bind alpha_glyph_blit_blend agbb_checker u_agbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
